// ===== design/vtdt_pkg.sv =====
// Package with the shared constants and types of the vertex triple dedup table.
`default_nettype none
package vtdt_pkg;

  // Table geometry. The depth must be a power of two, so the home slot is the
  // low bits of the hash and slot increments wrap by themselves.
  localparam int unsigned TABLE_DEPTH     = 4096;
  localparam int unsigned ATTR_INDEX_BITS = 24;

  localparam int unsigned SLOT_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned POS_W     = ATTR_INDEX_BITS;
  localparam int unsigned SIDE_W    = ATTR_INDEX_BITS + 1;
  localparam int unsigned OUT_IDX_W = 12;
  localparam int unsigned EPOCH_W   = 4;

  localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(TABLE_DEPTH);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_INIT = EPOCH_W'(1);

  // Hash primes. Only the low SLOT_W bits of each product reach the slot.
  localparam logic [31:0] PRIME_POS = 32'd73856093;
  localparam logic [31:0] PRIME_NRM = 32'd19349663;
  localparam logic [31:0] PRIME_TEX = 32'd83492791;
  localparam logic [SLOT_W-1:0] PRIME_POS_LO = SLOT_W'(PRIME_POS);
  localparam logic [SLOT_W-1:0] PRIME_NRM_LO = SLOT_W'(PRIME_NRM);
  localparam logic [SLOT_W-1:0] PRIME_TEX_LO = SLOT_W'(PRIME_TEX);

  // One table entry. An entry is live only when its tag equals the current epoch.
  typedef struct packed {
    logic [EPOCH_W-1:0]       tag;
    logic [POS_W-1:0]         pos;
    logic signed [SIDE_W-1:0] nrm;
    logic signed [SIDE_W-1:0] tex;
    logic [SLOT_W-1:0]        idx;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

endpackage
`default_nettype wire

// ===== design/vtdt_if.sv =====
// Handshake channel interfaces for face corners in and vertex results out.
`default_nettype none
interface vtdt_corner_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 first_of_mesh;
  logic [vtdt_pkg::POS_W-1:0]           position_index;
  logic signed [vtdt_pkg::SIDE_W-1:0]   nrm_index;
  logic signed [vtdt_pkg::SIDE_W-1:0]   tex_index;

  modport source (output valid, first_of_mesh, position_index, nrm_index,
                  tex_index, input ready);
  modport sink (input valid, first_of_mesh, position_index, nrm_index,
                tex_index, output ready);
endinterface

interface vtdt_vertex_if;
  logic                             valid;
  logic                             ready;
  logic [vtdt_pkg::OUT_IDX_W-1:0]   vert_index;
  logic                             is_new;
  logic                             table_full;

  modport source (output valid, vert_index, is_new, table_full, input ready);
  modport sink (input valid, vert_index, is_new, table_full, output ready);
endinterface
`default_nettype wire

// ===== design/vtdt_hash.sv =====
// Home slot hash: registered prime products, XOR at the output.
`default_nettype none
module vtdt_hash (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [vtdt_pkg::POS_W-1:0]         pos,
  input  wire logic signed [vtdt_pkg::SIDE_W-1:0] nrm,
  input  wire logic signed [vtdt_pkg::SIDE_W-1:0] tex,
  output logic [vtdt_pkg::SLOT_W-1:0]             slot
);

  logic [vtdt_pkg::SLOT_W-1:0] pos_lo, nrm_lo, tex_lo;
  logic [vtdt_pkg::SLOT_W-1:0] prod_pos, prod_nrm, prod_tex;

  // The size casts keep the low bits of each index, which are the same bits
  // a sign-extended index has, so the low bits of each product come out right.
  assign pos_lo = vtdt_pkg::SLOT_W'(pos);
  assign nrm_lo = vtdt_pkg::SLOT_W'(nrm);
  assign tex_lo = vtdt_pkg::SLOT_W'(tex);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_pos <= pos_lo * vtdt_pkg::PRIME_POS_LO;
      prod_nrm <= nrm_lo * vtdt_pkg::PRIME_NRM_LO;
      prod_tex <= tex_lo * vtdt_pkg::PRIME_TEX_LO;
    end
  end

  assign slot = prod_pos ^ prod_nrm ^ prod_tex;

endmodule
`default_nettype wire

// ===== design/vtdt_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module vtdt_store (
  input  wire logic              clk,
  input  wire vtdt_pkg::mem_wr_t wr,
  input  wire vtdt_pkg::mem_rd_t rd,
  output vtdt_pkg::entry_t       rdata
);

  vtdt_pkg::entry_t mem [vtdt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/vertex_triple_dedup_table.sv =====
// Top level of the vertex triple dedup table: probe sequencer and result register.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+---------------------------------------------------
//   corner   | in  | valid / ready | first_of_mesh, position_index, nrm_index, tex_index
//   vertex   | out | valid / ready | vert_index, is_new, table_full
//
// A corner's result word follows the hash register, the home slot read in S_READ
// and S_CHECK, where each extra probe past the home slot makes one more read of the
// entry memory's single read port. One corner is in flight at a time, so the next
// corner is accepted only once the result of the one before has been loaded.
// After reset the block runs a clearing pass over every entry of the entry memory
// before it accepts a corner. A mesh start bumps a 4-bit epoch instead of
// clearing; every 15th mesh start wraps the epoch and costs another clearing pass.
// A result waiting on a stalled vertex channel holds the sequencer.
`default_nettype none
module vertex_triple_dedup_table (
  input  wire logic    clk,
  input  wire logic    rst,
  vtdt_corner_if.sink  corner,
  vtdt_vertex_if.source vertex
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]                         state, state_next;
  logic [vtdt_pkg::EPOCH_W-1:0]       epoch, epoch_next;
  logic [vtdt_pkg::CNT_W-1:0]         count, count_next;
  logic                               pending, pending_next;
  logic [vtdt_pkg::SLOT_W-1:0]        clr_addr, clr_addr_next;
  logic [vtdt_pkg::SLOT_W-1:0]        slot, slot_next;
  logic [vtdt_pkg::SLOT_W-1:0]        probe_cnt, probe_cnt_next;

  // Key of the corner being looked up.
  logic [vtdt_pkg::POS_W-1:0]         key_pos;
  logic signed [vtdt_pkg::SIDE_W-1:0] key_nrm;
  logic signed [vtdt_pkg::SIDE_W-1:0] key_tex;

  // Result register toward the vertex channel.
  logic                               out_valid;
  logic [vtdt_pkg::OUT_IDX_W-1:0]     out_index, out_index_next;
  logic                               out_new, out_new_next;
  logic                               out_full, out_full_next;

  logic                               accept;
  logic                               res_go;
  logic                               res_load;
  logic                               entry_live;
  logic                               key_hit;
  logic [vtdt_pkg::SLOT_W-1:0]        home_slot;
  vtdt_pkg::entry_t                   rd_word;
  vtdt_pkg::mem_wr_t                  mem_wr;
  vtdt_pkg::mem_rd_t                  mem_rd;

  assign corner.ready = (state == S_IDLE);
  assign accept       = corner.valid && corner.ready;

  // The result register can take a new word when it is empty or being drained.
  assign res_go = !out_valid || vertex.ready;

  vtdt_hash u_hash (
    .clk  (clk),
    .load (accept),
    .pos  (corner.position_index),
    .nrm  (corner.nrm_index),
    .tex  (corner.tex_index),
    .slot (home_slot)
  );

  vtdt_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (rd_word)
  );

  // An entry whose tag is not the current epoch counts as empty.
  assign entry_live = (rd_word.tag == epoch);
  assign key_hit    = entry_live && (rd_word.pos == key_pos) &&
                      (rd_word.nrm == key_nrm) && (rd_word.tex == key_tex);

  always_ff @(posedge clk) begin
    if (accept) begin
      key_pos <= corner.position_index;
      key_nrm <= corner.nrm_index;
      key_tex <= corner.tex_index;
    end
  end

  always_comb begin
    state_next     = state;
    epoch_next     = epoch;
    count_next     = count;
    pending_next   = pending;
    clr_addr_next  = clr_addr;
    slot_next      = slot;
    probe_cnt_next = probe_cnt;
    res_load       = 1'b0;
    out_index_next = out_index;
    out_new_next   = out_new;
    out_full_next  = out_full;
    mem_wr         = '0;
    mem_rd         = '0;

    case (state)
      S_CLEAR: begin
        // Zero tags never match an epoch, so a cleared entry reads as empty.
        mem_wr.en     = 1'b1;
        mem_wr.addr   = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == vtdt_pkg::SLOT_LAST) begin
          state_next   = pending ? S_READ : S_IDLE;
          pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
          if (corner.first_of_mesh) begin
            count_next = '0;
            if (epoch == vtdt_pkg::EPOCH_MAX) begin
              // Epoch wrap: old tags could alias, so sweep the memory first.
              epoch_next    = vtdt_pkg::EPOCH_INIT;
              state_next    = S_CLEAR;
              pending_next  = 1'b1;
              clr_addr_next = '0;
            end else begin
              epoch_next = epoch + 1'b1;
            end
          end
        end
      end
      S_READ: begin
        mem_rd.en      = 1'b1;
        mem_rd.addr    = home_slot;
        slot_next      = home_slot;
        probe_cnt_next = '0;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (!entry_live) begin
          // Miss ending at a free entry: insert with the next dense index.
          if (res_go) begin
            mem_wr.en       = 1'b1;
            mem_wr.addr     = slot;
            mem_wr.data.tag = epoch;
            mem_wr.data.pos = key_pos;
            mem_wr.data.nrm = key_nrm;
            mem_wr.data.tex = key_tex;
            mem_wr.data.idx = vtdt_pkg::SLOT_W'(count);
            count_next      = count + 1'b1;
            res_load        = 1'b1;
            out_index_next  = vtdt_pkg::OUT_IDX_W'(vtdt_pkg::SLOT_W'(count));
            out_new_next    = 1'b1;
            out_full_next   = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (key_hit) begin
          if (res_go) begin
            res_load       = 1'b1;
            out_index_next = vtdt_pkg::OUT_IDX_W'(rd_word.idx);
            out_new_next   = 1'b0;
            out_full_next  = 1'b0;
            state_next     = S_IDLE;
          end
        end else if (probe_cnt == vtdt_pkg::SLOT_LAST) begin
          // Every slot holds some other triple: the table is full.
          if (res_go) begin
            res_load       = 1'b1;
            out_index_next = '0;
            out_new_next   = 1'b0;
            out_full_next  = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          // Linear probe: read the next slot, wrapping at the end of the table.
          mem_rd.en      = 1'b1;
          mem_rd.addr    = slot + 1'b1;
          slot_next      = slot + 1'b1;
          probe_cnt_next = probe_cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      epoch     <= vtdt_pkg::EPOCH_INIT;
      count     <= '0;
      pending   <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      epoch    <= epoch_next;
      count    <= count_next;
      pending  <= pending_next;
      clr_addr <= clr_addr_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (vertex.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot      <= slot_next;
    probe_cnt <= probe_cnt_next;
    if (res_load) begin
      out_index <= out_index_next;
      out_new   <= out_new_next;
      out_full  <= out_full_next;
    end
  end

  assign vertex.valid      = out_valid;
  assign vertex.vert_index = out_index;
  assign vertex.is_new     = out_new;
  assign vertex.table_full = out_full;

  // An insert right after a read lands on the slot that was just read.
  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (mem_wr.en && state == S_CHECK && $past(mem_rd.en))
      |-> (mem_wr.addr == $past(mem_rd.addr)))
    else $error("insert address differs from the probed slot");

  // An insert always finds room below the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (mem_wr.en && state == S_CHECK) |-> (count < vtdt_pkg::CNT_FULL))
    else $error("insert with a full unique count");

  // Epoch zero marks cleared entries and is never current.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("current epoch is zero");

  // An accepted corner goes straight to its lookup or to a clearing pass.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ || state == S_CLEAR))
    else $error("accepted corner not followed by lookup");

endmodule
`default_nettype wire

// ===== sim/vertex_triple_dedup_table_test.sv =====
// Self-checking testbench for the vertex triple dedup table.
`default_nettype none
module vertex_triple_dedup_table_test;

  // One corner word as offered on the input channel.
  typedef struct packed {
    logic                               first_of_mesh;
    logic [vtdt_pkg::POS_W-1:0]         pos;
    logic signed [vtdt_pkg::SIDE_W-1:0] nrm;
    logic signed [vtdt_pkg::SIDE_W-1:0] tex;
  } corner_word_t;

  // One vertex word as expected on the output channel.
  typedef struct packed {
    logic [vtdt_pkg::OUT_IDX_W-1:0] vert_index;
    logic                           is_new;
    logic                           table_full;
  } vertex_word_t;

  // Hash multipliers mod 2^64; position zero-extended, sides sign-extended.
  localparam logic [63:0] POS_MULT = 64'd73856093;
  localparam logic [63:0] NRM_MULT = 64'd19349663;
  localparam logic [63:0] TEX_MULT = 64'd83492791;

  // Marker for a missing normal or texcoord, and the extremes of a side index.
  localparam logic [vtdt_pkg::SIDE_W-1:0] ABSENT   = '1;
  localparam logic [vtdt_pkg::SIDE_W-1:0] SIDE_MAX = {1'b0, {(vtdt_pkg::SIDE_W-1){1'b1}}};
  localparam logic [vtdt_pkg::SIDE_W-1:0] SIDE_MIN = {1'b1, {(vtdt_pkg::SIDE_W-1){1'b0}}};
  localparam logic [vtdt_pkg::POS_W-1:0]  POS_MAX  = '1;

  localparam int unsigned IDLE_PERCENT  = 14;
  localparam int unsigned BACKLOG_HOLD  = 300;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic clk;
  logic rst;

  vtdt_corner_if corner_ch ();
  vtdt_vertex_if vertex_ch ();

  vertex_triple_dedup_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .corner (corner_ch),
    .vertex (vertex_ch)
  );

  // Corner words still to be offered, and vertex words predicted but not yet seen.
  corner_word_t pending_corners[$];
  vertex_word_t expected_vertices[$];
  int unsigned  mismatches;

  // Flags owned by the stimulus process and read by the driver and receiver.
  // They change only with nonblocking assignments at the rising edge.
  logic calm;
  logic backlog_req;

  // Set at each rising edge when the corner channel moved a word.
  bit corner_took;

  // Shadow copy of the dedup table: occupancy, stored triple and dense index.
  bit                             shadow_used[vtdt_pkg::TABLE_DEPTH];
  logic [vtdt_pkg::POS_W-1:0]     shadow_pos[vtdt_pkg::TABLE_DEPTH];
  logic [vtdt_pkg::SIDE_W-1:0]    shadow_nrm[vtdt_pkg::TABLE_DEPTH];
  logic [vtdt_pkg::SIDE_W-1:0]    shadow_tex[vtdt_pkg::TABLE_DEPTH];
  logic [vtdt_pkg::CNT_W-1:0]     shadow_vertex[vtdt_pkg::TABLE_DEPTH];
  logic [vtdt_pkg::CNT_W-1:0]     shadow_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run ends here only if the block hangs.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Home slot of a triple: the position is zero-extended and each side index
  // sign-extended to 64 bits ahead of its product; slot = hash modulo table depth.
  function automatic logic [vtdt_pkg::SLOT_W-1:0] home_slot(
      logic [vtdt_pkg::POS_W-1:0] p, logic [vtdt_pkg::SIDE_W-1:0] n,
      logic [vtdt_pkg::SIDE_W-1:0] t);
    logic [63:0] h;
    h = ({{(64-vtdt_pkg::POS_W){1'b0}}, p} * POS_MULT)
      ^ ({{(64-vtdt_pkg::SIDE_W){n[vtdt_pkg::SIDE_W-1]}}, n} * NRM_MULT)
      ^ ({{(64-vtdt_pkg::SIDE_W){t[vtdt_pkg::SIDE_W-1]}}, t} * TEX_MULT);
    return vtdt_pkg::SLOT_W'(h % vtdt_pkg::TABLE_DEPTH);
  endfunction

  // Looks a triple up in the shadow table, inserting it on a miss, and returns
  // the vertex word the block must produce for it. Linear probing stops at the
  // first matching entry (hit) or the first free one (miss); a full sweep with
  // neither means the table is full.
  function automatic vertex_word_t resolve_corner(logic fom,
      logic [vtdt_pkg::POS_W-1:0] p, logic [vtdt_pkg::SIDE_W-1:0] n,
      logic [vtdt_pkg::SIDE_W-1:0] t);
    vertex_word_t                r;
    logic [vtdt_pkg::SLOT_W-1:0] slot;
    if (fom) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_count = '0;
    end
    r.vert_index = '0;
    r.is_new     = 1'b0;
    r.table_full = 1'b1;
    slot = home_slot(p, n, t);
    for (int probe = 0; probe < vtdt_pkg::TABLE_DEPTH; probe++) begin
      if (!shadow_used[slot]) begin
        shadow_used[slot]   = 1'b1;
        shadow_pos[slot]    = p;
        shadow_nrm[slot]    = n;
        shadow_tex[slot]    = t;
        shadow_vertex[slot] = shadow_count;
        r.vert_index = shadow_count[vtdt_pkg::OUT_IDX_W-1:0];
        r.is_new     = 1'b1;
        r.table_full = 1'b0;
        shadow_count++;
        return r;
      end
      if (shadow_pos[slot] == p && shadow_nrm[slot] == n
          && shadow_tex[slot] == t) begin
        r.vert_index = shadow_vertex[slot][vtdt_pkg::OUT_IDX_W-1:0];
        r.table_full = 1'b0;
        return r;
      end
      slot++;
    end
    return r;
  endfunction

  // Side index with extra weight on absent, zero and the two extremes.
  function automatic logic [vtdt_pkg::SIDE_W-1:0] random_side();
    case ($urandom_range(9))
      0: return ABSENT;
      1: return '0;
      2: return SIDE_MAX;
      3: return SIDE_MIN;
      default: return vtdt_pkg::SIDE_W'($urandom);
    endcase
  endfunction

  function automatic corner_word_t random_corner();
    corner_word_t w;
    case ($urandom_range(7))
      0: w.pos = '0;
      1: w.pos = POS_MAX;
      default: w.pos = vtdt_pkg::POS_W'($urandom);
    endcase
    w.nrm = random_side();
    w.tex = random_side();
    w.first_of_mesh = 1'b0;
    return w;
  endfunction

  task automatic push_corner(logic fom, logic [vtdt_pkg::POS_W-1:0] p,
                             logic [vtdt_pkg::SIDE_W-1:0] n,
                             logic [vtdt_pkg::SIDE_W-1:0] t);
    corner_word_t w;
    w.first_of_mesh = fom;
    w.pos = p;
    w.nrm = n;
    w.tex = t;
    pending_corners.insert(pending_corners.size(), w);
  endtask

  // One mesh of random corners. Most corners are drawn from a small set of
  // triples, so that hits are common. Some triples in the set are near copies
  // of others: the position moved by a multiple of the table depth lands on the
  // same home slot and forces probing, and a single flipped normal or texcoord
  // bit checks that every key field takes part in the compare. The rest of the
  // corners are fresh triples that almost always miss.
  task automatic queue_random_mesh(int unsigned count);
    corner_word_t pool[$];
    corner_word_t w;
    int unsigned  pool_size;
    pool_size = $urandom_range(4, 24);
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        w = pool[$urandom_range(pool.size() - 1)];
        case ($urandom_range(2))
          0: w.pos += vtdt_pkg::POS_W'(vtdt_pkg::TABLE_DEPTH * $urandom_range(1, 15));
          1: w.tex[$urandom_range(vtdt_pkg::SIDE_W - 1)] ^= 1'b1;
          default: w.nrm[$urandom_range(vtdt_pkg::SIDE_W - 1)] ^= 1'b1;
        endcase
      end else begin
        w = random_corner();
      end
      pool.insert(pool.size(), w);
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) w = random_corner();
      else w = pool[$urandom_range(pool.size() - 1)];
      w.first_of_mesh = (i == 0);
      pending_corners.insert(pending_corners.size(), w);
    end
  endtask

  // Returns once every corner has been taken and every vertex word has come.
  // The corner side is looked at on the rising edge, where the driver leaves
  // it alone, and the expectations on the falling edge, where the monitor does.
  // It leaves the caller on a rising edge.
  task automatic wait_until_drained();
    forever begin
      @(posedge clk);
      if (pending_corners.size() == 0 && !corner_ch.valid) begin
        @(negedge clk);
        if (expected_vertices.size() == 0) break;
      end
    end
    @(posedge clk);
  endtask

  // Corner driver. A word stays on the channel until it is taken; gaps are
  // only ever inserted between words.
  always @(negedge clk) begin : drive_corners
    corner_word_t w;
    if (rst) begin
      corner_ch.valid <= 1'b0;
    end else if (!corner_ch.valid || corner_took) begin
      if (pending_corners.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        w = pending_corners.pop_front();
        corner_ch.valid          <= 1'b1;
        corner_ch.first_of_mesh  <= w.first_of_mesh;
        corner_ch.position_index <= w.pos;
        corner_ch.nrm_index      <= w.nrm;
        corner_ch.tex_index      <= w.tex;
      end else begin
        corner_ch.valid <= 1'b0;
      end
    end
  end

  // Vertex receiver. On request it holds ready low for a long stretch, counted
  // here, so that the block backs up and stalls the corner channel.
  always @(negedge clk) begin : drive_vertex_ready
    int unsigned hold_left;
    bit          backlog_done;
    if (rst) begin
      vertex_ch.ready <= 1'b0;
    end else if (backlog_req && !backlog_done) begin
      backlog_done = 1'b1;
      hold_left = BACKLOG_HOLD;
      vertex_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      vertex_ch.ready <= 1'b0;
    end else begin
      vertex_ch.ready <= calm || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // Monitor. Every corner taken is run through the shadow table at once, since
  // the block answers corners strictly in order; every vertex word taken is
  // checked against the oldest prediction.
  always @(posedge clk) begin : check_vertices
    vertex_word_t want;
    if (rst) begin
      corner_took <= 1'b0;
    end else begin
      corner_took <= corner_ch.valid && corner_ch.ready;
      if (corner_ch.valid && corner_ch.ready) begin
        expected_vertices.insert(expected_vertices.size(),
                                 resolve_corner(corner_ch.first_of_mesh,
                                                corner_ch.position_index,
                                                corner_ch.nrm_index,
                                                corner_ch.tex_index));
      end
      if (vertex_ch.valid && vertex_ch.ready) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t: vertex word with none expected: index=%0d new=%b full=%b",
                   $time, vertex_ch.vert_index, vertex_ch.is_new, vertex_ch.table_full);
          mismatches++;
        end else begin
          want = expected_vertices.pop_front();
          if (vertex_ch.vert_index !== want.vert_index || vertex_ch.is_new !== want.is_new
              || vertex_ch.table_full !== want.table_full) begin
            $display("%0t: vertex mismatch: expected index=%0d new=%b full=%b,",
                     $time, want.vert_index, want.is_new, want.table_full,
                     " got index=%0d new=%b full=%b",
                     vertex_ch.vert_index, vertex_ch.is_new, vertex_ch.table_full);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned mesh_len;
    mismatches  = 0;
    calm        = 1'b0;
    backlog_req = 1'b0;
    shadow_count = '0;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    rst = 1'b1;
    corner_ch.valid          = 1'b0;
    corner_ch.first_of_mesh  = 1'b0;
    corner_ch.position_index = '0;
    corner_ch.nrm_index      = '0;
    corner_ch.tex_index      = '0;
    vertex_ch.ready          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners. The first arrives on an empty table without a mesh
    // start. Then: an exact repeat, all fields at their maxima, the most
    // negative normal, triples that differ from an earlier one in only the
    // texcoord or only the normal, two positions that share a home slot with
    // the first triple and so must probe past it, hits found after probing,
    // a mesh start on a triple that was live (it must come back as new with
    // index zero), and alternating bit patterns.
    push_corner(1'b0, '0, ABSENT, ABSENT);
    push_corner(1'b0, '0, ABSENT, ABSENT);
    push_corner(1'b0, POS_MAX, SIDE_MAX, SIDE_MAX);
    push_corner(1'b0, POS_MAX, SIDE_MIN, '0);
    push_corner(1'b0, '0, ABSENT, '0);
    push_corner(1'b0, '0, '0, ABSENT);
    push_corner(1'b0, vtdt_pkg::POS_W'(vtdt_pkg::TABLE_DEPTH), ABSENT, ABSENT);
    push_corner(1'b0, vtdt_pkg::POS_W'(2 * vtdt_pkg::TABLE_DEPTH), ABSENT, ABSENT);
    push_corner(1'b0, vtdt_pkg::POS_W'(2 * vtdt_pkg::TABLE_DEPTH), ABSENT, ABSENT);
    push_corner(1'b0, '0, ABSENT, ABSENT);
    push_corner(1'b0, POS_MAX, SIDE_MAX, SIDE_MAX);
    push_corner(1'b1, vtdt_pkg::POS_W'(vtdt_pkg::TABLE_DEPTH), ABSENT, ABSENT);
    push_corner(1'b0, '0, ABSENT, ABSENT);
    push_corner(1'b0, vtdt_pkg::POS_W'(vtdt_pkg::TABLE_DEPTH), ABSENT, ABSENT);
    push_corner(1'b1, '0, ABSENT, ABSENT);
    push_corner(1'b0, 24'hAAAAAA, 25'h0555555, 25'h1AAAAAA);
    push_corner(1'b0, 24'h555555, 25'h1AAAAAA, 25'h0555555);
    push_corner(1'b0, 24'hAAAAAA, 25'h0555555, 25'h1AAAAAA);
    push_corner(1'b0, '0, SIDE_MIN, SIDE_MIN);
    push_corner(1'b0, '0, SIDE_MIN, SIDE_MIN);
    // Sender pauses here until every vertex word has come back.
    wait_until_drained();

    // Random meshes. The receiver first holds off for a long stretch while the
    // corners keep coming, then a middle stretch runs with no gaps on either
    // side, and the rest runs with random gaps.
    queued = 0;
    while (queued < 470) begin
      mesh_len = $urandom_range(10, 50);
      queue_random_mesh(mesh_len);
      queued += mesh_len;
    end
    backlog_req <= 1'b1;
    while (pending_corners.size() > queued / 2) @(posedge clk);
    calm <= 1'b1;
    while (pending_corners.size() > queued / 5) @(posedge clk);
    calm <= 1'b0;
    wait_until_drained();

    // Give a stray extra word time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
